@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the ROC area accumulator.
// Depends on nothing; every macro samples on clk_i and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

@@ hdl/raa_pkg.sv @@
// Shared types and constants of the ROC area accumulator.
// No dependencies; imported by the queue, front, back and top-level modules.
`default_nettype none

package raa_pkg;

  localparam int CNT_W       = 17;  // cumulative positive count
  localparam int AREA_W      = 17;  // Q1.16 area result
  localparam int STATUS_W    = 3;
  localparam int DATA_W      = 24;  // tdata width, whole bytes
  localparam int QUEUE_DEPTH = 2;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NO_POS   = 3'd2,
    ST_NO_NEG   = 3'd3,
    ST_BAD_STEP = 3'd4
  } status_e;

endpackage

`default_nettype wire

@@ hdl/roc_area_accumulator_core.sv @@
// Top level of the ROC area accumulator: front, job queue and back part.
// Depends on raa_pkg, raa_front, raa_queue, raa_back and assert_macros.svh.
//
// Usage:
//   Slave stream: one transaction per item, in ascending score order. tdata
//   carries the running count of positive labels, tlast marks the final item
//   of a data set. The front takes one item per cycle while the job queue
//   has room.
//   Master stream: one transaction per data set, issued after its tlast item.
//   tdata carries the area (unsigned Q1.FRACTION_BITS, truncated, saturated),
//   tuser the status code; the area is zero whenever the status is not OK.
//   Results: the job of a data set is written to the queue and picked up by
//   the back part when it is free, which multiplies, prepares and then runs up
//   to 18 restoring-division steps (the saturation check plus one per quotient
//   bit), fewer on saturation; an error status skips the arithmetic. The
//   division loop sets the data-set rate.
//   A stalled master holds the result; the front keeps accepting items and
//   up to two finished data sets wait in the queue before tready drops.
//   Reset (rst_ni low, asynchronous) empties the queue, clears all
//   accumulators and returns the back part to idle.
`default_nettype none
`include "assert_macros.svh"

module roc_area_accumulator_core
  import raa_pkg::*;
#(
  parameter int MAX_ITEMS     = 65536,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,  // [16:0] positive_count, rest zero
  input  wire logic              s_axis_tlast,  // last_item
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [DATA_W-1:0]      m_axis_tdata,  // [16:0] roc_area, rest zero
  output logic [STATUS_W-1:0]    m_axis_tuser   // [2:0] status
);

  localparam int NI_W  = $clog2(MAX_ITEMS + 1);
  localparam int WW    = NI_W + CNT_W;
  localparam int JOB_W = STATUS_W + CNT_W + 2 * NI_W + WW + 2;

  status_e           f_status, b_status, q_status, res_status;
  logic [CNT_W-1:0]  f_p, q_p;
  logic [NI_W-1:0]   f_n, f_z, q_n, q_z;
  logic [WW-1:0]     f_w, q_w;
  logic              f_second, f_first, q_second, q_first;
  logic              job_valid, job_ready, pop_valid, pop_ready;
  logic [JOB_W-1:0]  push_data, pop_data;
  logic [AREA_W-1:0] res_area;

  raa_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .count_i      (s_axis_tdata[CNT_W-1:0]),
    .last_i       (s_axis_tlast),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_status_o (f_status),
    .job_p_o      (f_p),
    .job_n_o      (f_n),
    .job_z_o      (f_z),
    .job_w_o      (f_w),
    .job_second_o (f_second),
    .job_first_o  (f_first)
  );

  // Pack one job per data set for the queue.
  assign push_data = {f_status, f_p, f_n, f_z, f_w, f_second, f_first};

  raa_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign q_status = status_e'(pop_data[JOB_W-1 -: STATUS_W]);
  assign {q_p, q_n, q_z, q_w, q_second, q_first} = pop_data[JOB_W-STATUS_W-1:0];
  assign b_status = q_status;

  raa_back #(
    .MAX_ITEMS     (MAX_ITEMS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (pop_valid),
    .job_ready_o  (pop_ready),
    .job_status_i (b_status),
    .job_p_i      (q_p),
    .job_n_i      (q_n),
    .job_z_i      (q_z),
    .job_w_i      (q_w),
    .job_second_i (q_second),
    .job_first_i  (q_first),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_area_o   (res_area),
    .res_status_o (res_status)
  );

  // Zero-pad the area to whole bytes.
  assign m_axis_tdata = DATA_W'(res_area);
  assign m_axis_tuser = res_status;

  // An error status always carries a zero area.
  `ASSERT_NEVER(a_err_area_zero, m_axis_tvalid && (m_axis_tuser != ST_OK) && (res_area != '0), "nonzero area with error status")
  // The back part takes a job only from idle, so two pickups never abut.
  `ASSERT_CLK(a_pop_spacing, (pop_valid && pop_ready) |=> !(pop_valid && pop_ready), "back part took jobs on consecutive cycles")

endmodule

`default_nettype wire

@@ hdl/raa_queue.sv @@
// Short job queue between the front and back parts of the ROC area accumulator.
// Depends on raa_pkg for the queue depth.
`default_nettype none

module raa_queue
  import raa_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]  entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_QW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/raa_front.sv @@
// Front part: accepts count items, checks steps, accumulates z and W per data set.
// Depends on raa_pkg; hands one classified job per data set to the queue.
`default_nettype none

module raa_front
  import raa_pkg::*;
#(
  parameter int MAX_ITEMS = 65536
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  item_valid_i,
  output logic                                       item_ready_o,
  input  wire logic [CNT_W-1:0]                      count_i,
  input  wire logic                                  last_i,
  output logic                                       job_valid_o,
  input  wire logic                                  job_ready_i,
  output status_e                                    job_status_o,
  output logic [CNT_W-1:0]                           job_p_o,
  output logic [$clog2(MAX_ITEMS+1)-1:0]             job_n_o,
  output logic [$clog2(MAX_ITEMS+1)-1:0]             job_z_o,
  output logic [$clog2(MAX_ITEMS+1)+CNT_W-1:0]       job_w_o,
  output logic                                       job_second_o,
  output logic                                       job_first_o
);

  localparam int NI_W = $clog2(MAX_ITEMS + 1);
  localparam int WW   = NI_W + CNT_W;
  localparam int CW   = (NI_W > CNT_W) ? NI_W : CNT_W;

  logic [CNT_W-1:0] prev_q, prev_d, step;
  logic             first_q, first_d, second_q, second_d, err_q, err_d;
  logic [NI_W-1:0]  idx_q, idx_d, z_q, z_d;
  logic [WW-1:0]    w_q, w_d;
  logic             accept;

  assign item_ready_o = job_ready_i;
  assign accept       = item_valid_i && item_ready_o;
  assign job_valid_o  = item_valid_i && last_i;
  assign step         = count_i - prev_q;

  always_comb begin
    prev_d   = count_i;
    first_d  = first_q;
    second_d = second_q;
    err_d    = err_q;
    idx_d    = idx_q;
    z_d      = z_q;
    w_d      = w_q;
    priority if (idx_q >= NI_W'(MAX_ITEMS)) begin
      err_d = 1'b1;
    end else if (idx_q == '0) begin
      if (count_i > CNT_W'(1)) begin
        err_d = 1'b1;
      end
      first_d = count_i[0];
      idx_d   = NI_W'(1);
    end else begin
      if ((count_i < prev_q) || (step > CNT_W'(1))) begin
        err_d = 1'b1;
      end else begin
        if (idx_q == NI_W'(1)) begin
          second_d = step[0];
        end
        if (step == '0) begin
          z_d = z_q + 1'b1;
          w_d = w_q + WW'(count_i);
        end
      end
      idx_d = idx_q + 1'b1;
    end
  end

  // Classify the data set from the state it leaves behind.
  always_comb begin
    if (idx_d < NI_W'(2)) begin
      job_status_o = ST_SHORT;
    end else if (err_d) begin
      job_status_o = ST_BAD_STEP;
    end else if (count_i == '0) begin
      job_status_o = ST_NO_POS;
    end else if (CW'(count_i) >= CW'(idx_d)) begin
      job_status_o = ST_NO_NEG;
    end else begin
      job_status_o = ST_OK;
    end
  end

  assign job_p_o      = count_i;
  assign job_n_o      = idx_d;
  assign job_z_o      = z_d;
  assign job_w_o      = w_d;
  assign job_second_o = second_d;
  assign job_first_o  = first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      first_q  <= 1'b0;
      second_q <= 1'b0;
      err_q    <= 1'b0;
      idx_q    <= '0;
      z_q      <= '0;
      w_q      <= '0;
    end else if (accept) begin
      if (last_i) begin
        prev_q   <= '0;
        first_q  <= 1'b0;
        second_q <= 1'b0;
        err_q    <= 1'b0;
        idx_q    <= '0;
        z_q      <= '0;
        w_q      <= '0;
      end else begin
        prev_q   <= prev_d;
        first_q  <= first_d;
        second_q <= second_d;
        err_q    <= err_d;
        idx_q    <= idx_d;
        z_q      <= z_d;
        w_q      <= w_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/raa_back.sv @@
// Back part: forms T and the denominator, divides one quotient bit a cycle.
// Depends on raa_pkg; holds the result in an output register until taken.
`default_nettype none

module raa_back
  import raa_pkg::*;
#(
  parameter int MAX_ITEMS     = 65536,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  job_valid_i,
  output logic                                       job_ready_o,
  input  status_e                                    job_status_i,
  input  wire logic [CNT_W-1:0]                      job_p_i,
  input  wire logic [$clog2(MAX_ITEMS+1)-1:0]        job_n_i,
  input  wire logic [$clog2(MAX_ITEMS+1)-1:0]        job_z_i,
  input  wire logic [$clog2(MAX_ITEMS+1)+CNT_W-1:0]  job_w_i,
  input  wire logic                                  job_second_i,
  input  wire logic                                  job_first_i,
  output logic                                       res_valid_o,
  input  wire logic                                  res_ready_i,
  output logic [AREA_W-1:0]                          res_area_o,
  output status_e                                    res_status_o
);

  localparam int NI_W = $clog2(MAX_ITEMS + 1);
  localparam int CW   = (NI_W > CNT_W) ? NI_W : CNT_W;
  localparam int PZ_W = CNT_W + NI_W;
  localparam int TW   = PZ_W + 2;
  localparam int RW_A = TW + FRACTION_BITS;
  localparam int RW_B = PZ_W + AREA_W + 2;
  localparam int RW   = (RW_A > RW_B) ? RW_A : RW_B;
  localparam int KW   = $clog2(AREA_W + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } back_state_e;

  back_state_e      state_q, state_d;
  status_e          status_q;
  logic [CNT_W-1:0] p_q, end_term;
  logic [NI_W-1:0]  n_q, z_q, neg;
  logic [CW-1:0]    neg_wide;
  logic [PZ_W-1:0]  w_q, pz_q, pn_q, diff;
  logic             second_q, first_q;
  logic [TW-1:0]    t_sum;
  logic [RW-1:0]    num_q, dsh_q;
  logic [AREA_W-1:0] quo_q, area_q;
  logic [KW-1:0]    k_q;
  logic             ge, sat_hit, div_done;

  assign neg_wide = CW'(n_q) - CW'(p_q);
  assign neg      = neg_wide[NI_W-1:0];
  assign diff     = pz_q - w_q;
  assign end_term = second_q ? '0 : (p_q - CNT_W'(first_q));
  assign t_sum    = TW'({diff, 1'b0}) + TW'(end_term);
  assign ge       = (num_q >= dsh_q);
  assign sat_hit  = (k_q == KW'(AREA_W)) && ge;
  assign div_done = sat_hit || (k_q == '0);

  assign job_ready_o  = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_OUT);
  assign res_area_o   = area_q;
  assign res_status_o = status_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_status_i == ST_OK) ? S_MUL : S_OUT;
        end
      end
      S_MUL:  state_d = S_PREP;
      S_PREP: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          status_q <= job_status_i;
          p_q      <= job_p_i;
          n_q      <= job_n_i;
          z_q      <= job_z_i;
          w_q      <= job_w_i;
          second_q <= job_second_i;
          first_q  <= job_first_i;
          area_q   <= '0;
        end
      end
      S_MUL: begin
        pz_q <= p_q * z_q;
        pn_q <= p_q * neg;
      end
      S_PREP: begin
        // Start with the divisor scaled by 2^AREA_W to catch saturation first.
        num_q <= RW'(t_sum) << FRACTION_BITS;
        dsh_q <= RW'({pn_q, 1'b0}) << AREA_W;
        quo_q <= '0;
        k_q   <= KW'(AREA_W);
      end
      S_DIV: begin
        if (ge) begin
          num_q <= num_q - dsh_q;
        end
        dsh_q <= dsh_q >> 1;
        k_q   <= k_q - 1'b1;
        quo_q <= {quo_q[AREA_W-2:0], ge};
        if (sat_hit) begin
          area_q <= AREA_MAX;
        end else if (k_q == '0) begin
          area_q <= {quo_q[AREA_W-2:0], ge};
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ sim/roc_area_accumulator_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for roc_area_accumulator_core: streams positive-count runs
// and checks each area/status transaction against an in-bench trapezoid-sum predictor.
// Depends on raa_pkg and the core RTL only.

module roc_area_accumulator_core_tb;
  import raa_pkg::*;

  localparam int     LIMIT_ITEMS   = 65536;   // data-set length before the overflow error
  localparam int     FRAC_BITS     = 16;
  localparam int     RANDOM_ITEMS  = 600;
  localparam int     END_SLACK     = 40;      // margin after the expectation queue has drained
  localparam longint CYCLE_LIMIT   = 1500000;

  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    status_e           status;
  } roc_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata;   // [16:0] positive_count, rest zero
  logic                s_axis_tlast;   // last_item
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [DATA_W-1:0]   m_axis_tdata;   // [16:0] roc_area, rest zero
  logic [STATUS_W-1:0] m_axis_tuser;   // [2:0] status

  roc_area_accumulator_core #(
    .MAX_ITEMS    (LIMIT_ITEMS),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow of the running accumulation for the open data set.
  // ---------------------------------------------------------------------------
  count_t          prev_cnt;
  logic            first_bit;      // c[0]
  logic            second_step;    // d[1]
  int              seen_items;     // saturates at LIMIT_ITEMS
  longint unsigned flat_steps;     // number of zero steps (z)
  longint unsigned flat_sum;       // sum of c over zero steps (W)
  bit              step_bad;

  roc_result_t     area_expect_q[$];
  count_t          run_counts[$];

  int              mismatch_count;
  longint          cycle_count;
  bit              tx_quiet;       // suppress sender gaps
  bit              rx_quiet;       // suppress receiver stalls
  int              rx_stall_left;

  function automatic void clear_run();
    prev_cnt    = '0;
    first_bit   = 1'b0;
    second_step = 1'b0;
    seen_items  = 0;
    flat_steps  = 0;
    flat_sum    = 0;
    step_bad    = 1'b0;
  endfunction

  // Fold one accepted item into the shadow state; on the last item queue the result.
  function automatic void predict_roc_item(input count_t cnt, input logic last);
    longint unsigned n, p, neg, t, den, q;
    roc_result_t     res;
    if (seen_items >= LIMIT_ITEMS) begin
      step_bad = 1'b1;
    end else if (seen_items == 0) begin
      if (cnt > 1) step_bad = 1'b1;
      first_bit  = cnt[0];
      seen_items = 1;
    end else begin
      if (cnt < prev_cnt || (cnt - prev_cnt) > 1) begin
        step_bad = 1'b1;
      end else begin
        if (seen_items == 1) second_step = (cnt != prev_cnt);
        if (cnt == prev_cnt) begin
          flat_steps++;
          flat_sum += cnt;
        end
      end
      seen_items++;
    end
    prev_cnt = cnt;
    if (!last) return;

    n          = seen_items;
    p          = cnt;
    res.area   = '0;
    res.status = ST_OK;
    if (n < 2) begin
      res.status = ST_SHORT;
    end else if (step_bad) begin
      res.status = ST_BAD_STEP;
    end else if (p == 0) begin
      res.status = ST_NO_POS;
    end else if (p >= n) begin
      res.status = ST_NO_NEG;
    end else begin
      neg = n - p;
      t   = 2 * (p * flat_steps - flat_sum) + (second_step ? 0 : (p - first_bit));
      den = 2 * p * neg;
      q   = (t << FRAC_BITS) / den;
      // Saturate anything at or above 2.0 in Q1.16.
      res.area = (q > AREA_MAX) ? AREA_MAX : q[AREA_W-1:0];
    end
    area_expect_q.push_back(res);
    clear_run();
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long hold-off.
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: present one count, hold until the transaction completes, predict.
  // ---------------------------------------------------------------------------
  task automatic send_count(input count_t cnt, input logic last);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(DATA_W-CNT_W){1'b0}}, cnt};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_roc_item(cnt, last);
  endtask

  // Send run_counts as one data set, tlast on the final entry.
  task automatic send_run();
    for (int i = 0; i < run_counts.size(); i++) begin
      send_count(run_counts[i], i == run_counts.size() - 1);
    end
    run_counts.delete();
  endtask

  // Drop tvalid and hold until every outstanding result has been checked.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (area_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Single-item data sets: under two items outranks even a bad first count.
  task automatic test_short_runs();
    run_counts = '{17'd0};
    send_run();
    run_counts = '{17'h1FFFF};
    send_run();
  endtask

  // No positives, no negatives and bad steps, and bad step outranking no positives / no negatives.
  task automatic test_error_status();
    run_counts = '{17'd0, 17'd0};                // no positives
    send_run();
    run_counts = '{17'd1, 17'd2};                // no negatives
    send_run();
    run_counts = '{17'd2, 17'd2, 17'd3};         // first count above one
    send_run();
    run_counts = '{17'd0, 17'd1, 17'd0};         // count decreases
    send_run();
    run_counts = '{17'd1, 17'd0, 17'd0};         // decrease ending with no positives
    send_run();
    run_counts = '{17'd0, 17'd0, 17'h10000};     // rise by more than one
    send_run();
  endtask

  // Well-formed sets with a real area, including both half-term end cases.
  task automatic test_valid_areas();
    run_counts = '{17'd1, 17'd1};
    send_run();
    run_counts = '{17'd0, 17'd1};
    send_run();
    run_counts = '{17'd0, 17'd0, 17'd1};
    send_run();
    run_counts = '{17'd0, 17'd1, 17'd1, 17'd2, 17'd2, 17'd2, 17'd3, 17'd3};
    send_run();
  endtask

  // Random data sets: mostly legal ramps, some corrupted, some single items.
  task automatic test_random_runs();
    int     sent, len, rate, bad_at, pick;
    count_t c;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) len = 1;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(17, 120);
      else len = $urandom_range(2, 16);

      pick = $urandom_range(0, 9);
      if (pick == 0) rate = 0;
      else if (pick == 1) rate = 100;
      else rate = $urandom_range(5, 95);

      bad_at   = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, len - 1)) : -1;
      tx_quiet = ($urandom_range(0, 7) == 0);
      rx_quiet = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 19) == 0) wait_drained();

      c = '0;
      for (int i = 0; i < len; i++) begin
        if (i == bad_at) begin
          case ($urandom_range(0, 2))
            0:       c = count_t'($urandom_range(0, 17'h1FFFF));
            1:       c = c + count_t'(2);
            default: c = c - count_t'(1);
          endcase
        end else if (i == 0) begin
          c = ($urandom_range(0, 99) < rate) ? count_t'(1) : count_t'(0);
        end else if ($urandom_range(0, 99) < rate) begin
          c = c + count_t'(1);
        end
        send_count(c, i == len - 1);
      end
      sent += len;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, with quiet stretches that leave tready high.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_quiet && $urandom_range(0, 3) == 0) rx_stall_left <= pick_gap(1'b0);
    end
  end

  // Check every completed result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    roc_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (area_expect_q.size() == 0) begin
        $error("unexpected result: roc_area %0h status %0d",
               m_axis_tdata[AREA_W-1:0], m_axis_tuser);
        mismatch_count++;
      end else begin
        exp_res = area_expect_q.pop_front();
        if (m_axis_tdata[AREA_W-1:0] !== exp_res.area) begin
          $error("roc_area: expected %0h, got %0h", exp_res.area, m_axis_tdata[AREA_W-1:0]);
          mismatch_count++;
        end
        if (m_axis_tuser !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: bound the run well beyond the slowest legal schedule.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tlast   <= 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    tx_quiet       = 1'b0;
    rx_quiet       = 1'b0;
    rx_stall_left  = 0;
    clear_run();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_runs();
    test_error_status();
    wait_drained();
    test_valid_areas();
    wait_drained();
    test_random_runs();

    wait_drained();
    repeat (END_SLACK) @(posedge clk_i);
    if (mismatch_count == 0 && area_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/raa_pkg.sv
hdl/raa_queue.sv
hdl/raa_front.sv
hdl/raa_back.sv
hdl/roc_area_accumulator_core.sv
sim/roc_area_accumulator_core_tb.sv
